### design/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and helpers of the scanline polygon fill unit.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 16;
	localparam int RES_LIMIT    = 16;

	localparam int IDX_BITS   = $clog2(MAX_VERTICES);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int RES_BITS   = $clog2(RES_LIMIT) + 1;
	localparam int X_BITS     = COORD_BITS + FRAC_BITS + 2;
	localparam int SLOPE_BITS = COORD_BITS + FRAC_BITS + 1;
	localparam int NUM_BITS   = COORD_BITS + FRAC_BITS + 1;
	localparam int ROW_BITS   = COORD_BITS + 1;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_EMIT  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DROP  = 2'd1;
	localparam logic [1:0] STAT_NOROW = 2'd2;

	typedef struct packed {
		logic [1:0]            action;
		logic [COORD_BITS-1:0] vertex_x;
		logic [COORD_BITS-1:0] vertex_y;
		logic                  last_vertex;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic                  span_valid;
		logic [COORD_BITS-1:0] span_y;
		logic [COORD_BITS-1:0] span_start;
		logic [COORD_BITS-1:0] span_end;
		logic [23:0]           span_color;
		logic                  last_of_run;
		logic                  polygon_done;
	} rsp_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} vertex_t;

	typedef struct packed {
		logic signed [X_BITS-1:0]     x;
		logic signed [SLOPE_BITS-1:0] slope;
		logic [COORD_BITS-1:0]        top;
	} edge_t;

	// Order by x, then by slope.
	function automatic logic edge_before(edge_t a, edge_t b);
		if (a.x != b.x) begin
			return a.x < b.x;
		end
		return a.slope < b.slope;
	endfunction

	// Round half up to a pixel, then clamp to the coordinate range.
	function automatic logic [COORD_BITS-1:0] round_clamp(logic signed [X_BITS-1:0] x);
		logic signed [X_BITS:0]           t;
		logic signed [X_BITS-FRAC_BITS:0] r;
		t = {x[X_BITS-1], x} + (X_BITS+1)'(1 << (FRAC_BITS - 1));
		r = t[X_BITS:FRAC_BITS];
		if (r < 0) begin
			return '0;
		end
		if (r > (X_BITS-FRAC_BITS+1)'((1 << COORD_BITS) - 1)) begin
			return '1;
		end
		return r[COORD_BITS-1:0];
	endfunction

endpackage

### design/spf_div.sv
// ----------------------------------------------------------------------------
// spf_div
// Restoring divider, one quotient bit per cycle, for edge slopes.
// ----------------------------------------------------------------------------
module spf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spf_pkg::NUM_BITS-1:0]  num,
	input  logic [spf_pkg::COORD_BITS-1:0] den,
	output logic                          done,
	output logic [spf_pkg::NUM_BITS-1:0]  quot
);
	import spf_pkg::*;

	localparam int STEP_BITS = $clog2(NUM_BITS);

	logic [COORD_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0]   quo_q;
	logic [COORD_BITS-1:0] den_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COORD_BITS:0]   shifted;
	logic                  fits;
	logic [COORD_BITS:0]   diff;

	assign shifted = {rem_q, quo_q[NUM_BITS-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				step_q <= STEP_BITS'(NUM_BITS - 1);
			end else if (busy_q) begin
				rem_q <= fits ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
				quo_q <= {quo_q[NUM_BITS-2:0], fits};
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

### design/scanline_polygon_fill_unit.sv
// ----------------------------------------------------------------------------
// scanline_polygon_fill_unit
// Active edge table polygon filler: loads vertices, then emits spans per row.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time. Clear, add-vertex and no-op
// requests give one response each. An emit request walks the stored vertices
// (reading each vertex and, for a vertex that lies on the row, both of its
// neighbours), runs the shared bit-serial divider for every edge that starts
// on the row, insertion-sorts the active edge table through its single read
// port, reads the table in pairs to form spans and finally sweeps it once more
// to step x and drop finished edges. Response back-pressure can stall a row.
// No clearing pass is needed after reset.
module scanline_polygon_fill_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spf_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output spf_pkg::rsp_t  rsp_data,
	input  logic           cfg_wr_en,
	input  logic [23:0]    cfg_wr_data
);
	import spf_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_VRD  = 4'd1;
	localparam logic [3:0] S_VCHK = 4'd2;
	localparam logic [3:0] S_NRD  = 4'd3;
	localparam logic [3:0] S_NCHK = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_SA   = 4'd6;
	localparam logic [3:0] S_SB   = 4'd7;
	localparam logic [3:0] S_SC   = 4'd8;
	localparam logic [3:0] S_SD   = 4'd9;
	localparam logic [3:0] S_OA   = 4'd10;
	localparam logic [3:0] S_OB   = 4'd11;
	localparam logic [3:0] S_OC   = 4'd12;
	localparam logic [3:0] S_OFIN = 4'd13;
	localparam logic [3:0] S_KA   = 4'd14;
	localparam logic [3:0] S_KB   = 4'd15;

	// Sequencer and polygon state
	logic [3:0]            st_q;
	logic [23:0]           fill_color_q;
	logic [CNT_BITS-1:0]   vcnt_q;
	logic                  closed_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [COORD_BITS-1:0] low_q;
	logic [COORD_BITS-1:0] high_q;
	logic [COORD_BITS-1:0] vmin_q;
	logic [COORD_BITS-1:0] vmax_q;
	logic [CNT_BITS-1:0]   ecnt_q;

	// Per-row working registers
	logic [CNT_BITS-1:0]   i_q;
	logic [CNT_BITS-1:0]   j_q;
	logic [CNT_BITS-1:0]   keep_q;
	logic                  phase_q;
	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] top_q;
	logic                  neg_q;
	logic                  done_row_q;
	edge_t                 tmp_q;
	logic [COORD_BITS-1:0] sa_q;
	logic                  pend_q;
	logic [COORD_BITS-1:0] pend_s_q;
	logic [COORD_BITS-1:0] pend_e_q;
	logic [RES_BITS-1:0]   k_q;

	// Memories
	vertex_t vmem [MAX_VERTICES];
	vertex_t vrd_q;
	edge_t   emem [MAX_VERTICES];
	edge_t   erd_q;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 can_push;
	logic                 accept;
	logic                 push_en;
	rsp_t                 push_data;
	logic [IDX_BITS-1:0]  vaddr;
	logic [IDX_BITS-1:0]  eaddr;
	logic                 ewe;
	logic [IDX_BITS-1:0]  ewaddr;
	edge_t                ewdata;
	logic                 div_start;
	logic                 div_done;
	logic [NUM_BITS-1:0]  div_quot;

	// Neighbour, edge candidate and span arithmetic
	logic [CNT_BITS-1:0]        nbr;
	logic                       edge_ok;
	logic signed [COORD_BITS:0] dx;
	logic [COORD_BITS-1:0]      mag;
	logic [COORD_BITS-1:0]      dy;
	logic [NUM_BITS-1:0]        num;
	logic [SLOPE_BITS-1:0]      qpos;
	logic signed [SLOPE_BITS-1:0] slope_new;
	logic                       tmp_first;
	logic [COORD_BITS-1:0]      eb;
	logic                       span_ok;
	logic [ROW_BITS-1:0]        row_next;
	logic                       keep_ok;
	logic                       vfull;
	logic [COORD_BITS-1:0]      nmin;
	logic [COORD_BITS-1:0]      nmax;

	assign can_push  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !(st_q == S_IDLE && can_push);
	assign accept    = req_valid && !req_stall;

	assign nbr = !phase_q ? ((i_q == '0) ? vcnt_q - 1'b1 : i_q - 1'b1)
	                      : ((i_q == vcnt_q - 1'b1) ? '0 : i_q + 1'b1);

	assign edge_ok = (vrd_q.y > cur_y_q) && (ecnt_q < CNT_BITS'(MAX_VERTICES));
	assign dx      = $signed({1'b0, vrd_q.x}) - $signed({1'b0, cur_x_q});
	assign mag     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign dy      = vrd_q.y - cur_y_q;
	assign num     = {1'b0, mag, {FRAC_BITS{1'b0}}} + NUM_BITS'(dy >> 1);
	assign qpos    = {1'b0, div_quot[NUM_BITS-2:0]};
	assign slope_new = neg_q ? -$signed(qpos) : $signed(qpos);

	assign tmp_first = edge_before(tmp_q, erd_q);
	assign eb        = round_clamp(erd_q.x);
	assign span_ok   = sa_q < eb;
	assign row_next  = row_q + 1'b1;
	assign keep_ok   = row_next < {1'b0, erd_q.top};

	assign vfull = vcnt_q == CNT_BITS'(MAX_VERTICES);
	assign nmin  = (vcnt_q == '0 || req_data.vertex_y < vmin_q) ? req_data.vertex_y : vmin_q;
	assign nmax  = (vcnt_q == '0 || req_data.vertex_y > vmax_q) ? req_data.vertex_y : vmax_q;

	spf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (dy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Addresses, table writes and response pushes of the current step
	always_comb begin
		vaddr     = i_q[IDX_BITS-1:0];
		eaddr     = '0;
		ewe       = 1'b0;
		ewaddr    = '0;
		ewdata    = tmp_q;
		push_en   = 1'b0;
		push_data = '0;
		div_start = 1'b0;
		push_data.last_of_run = 1'b1;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					case (req_data.action)
						ACT_CLEAR: push_en = 1'b1;
						ACT_ADD: begin
							push_en = 1'b1;
							push_data.status = (closed_q || vfull) ? STAT_DROP : STAT_OK;
						end
						ACT_EMIT: begin
							if (!closed_q || row_q > {1'b0, high_q}) begin
								push_en = 1'b1;
								push_data.status = STAT_NOROW;
							end
						end
						default: push_en = 1'b1;
					endcase
				end
			end
			S_NRD: vaddr = nbr[IDX_BITS-1:0];
			S_NCHK: div_start = edge_ok;
			S_DIV: begin
				if (div_done) begin
					ewe          = 1'b1;
					ewaddr       = ecnt_q[IDX_BITS-1:0];
					ewdata.x     = $signed({2'b00, cur_x_q, {FRAC_BITS{1'b0}}});
					ewdata.slope = slope_new;
					ewdata.top   = top_q;
				end
			end
			S_SA: eaddr = i_q[IDX_BITS-1:0];
			S_SB: eaddr = IDX_BITS'(i_q - 1'b1);
			S_SC: begin
				ewe    = 1'b1;
				ewaddr = j_q[IDX_BITS-1:0];
				eaddr  = IDX_BITS'(j_q - 2'd2);
				if (tmp_first) begin
					ewdata = erd_q;
				end
			end
			S_SD: begin
				ewe    = 1'b1;
				ewaddr = '0;
			end
			S_OA: eaddr = i_q[IDX_BITS-1:0];
			S_OB: eaddr = IDX_BITS'(i_q + 1'b1);
			S_OC: begin
				eaddr = IDX_BITS'(i_q + 1'b1);
				if (span_ok && pend_q && can_push) begin
					push_en                = 1'b1;
					push_data.span_valid   = 1'b1;
					push_data.span_y       = row_q[COORD_BITS-1:0];
					push_data.span_start   = pend_s_q;
					push_data.span_end     = pend_e_q;
					push_data.span_color   = fill_color_q;
					push_data.last_of_run  = 1'b0;
					push_data.polygon_done = done_row_q;
				end
			end
			S_OFIN: begin
				if (can_push) begin
					push_en                = 1'b1;
					push_data.span_valid   = pend_q;
					push_data.span_y       = row_q[COORD_BITS-1:0];
					push_data.span_start   = pend_q ? pend_s_q : '0;
					push_data.span_end     = pend_q ? pend_e_q : '0;
					push_data.span_color   = pend_q ? fill_color_q : '0;
					push_data.polygon_done = done_row_q;
				end
			end
			S_KA: eaddr = i_q[IDX_BITS-1:0];
			S_KB: begin
				if (keep_ok) begin
					ewe          = 1'b1;
					ewaddr       = keep_q[IDX_BITS-1:0];
					ewdata.x     = erd_q.x + X_BITS'(erd_q.slope);
					ewdata.slope = erd_q.slope;
					ewdata.top   = erd_q.top;
				end
			end
			default: ;
		endcase
	end

	// Vertex store: written on add, read one address a cycle
	always_ff @(posedge clk) begin
		if (accept && req_data.action == ACT_ADD && !closed_q && !vfull) begin
			vmem[vcnt_q[IDX_BITS-1:0]] <= '{x: req_data.vertex_x, y: req_data.vertex_y};
		end
		vrd_q <= vmem[vaddr];
	end

	// Active edge table
	always_ff @(posedge clk) begin
		if (ewe) begin
			emem[ewaddr] <= ewdata;
		end
		erd_q <= emem[eaddr];
	end

	// Response register: hold until taken, refill in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (push_en) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= push_data;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= '0;
		end else if (cfg_wr_en) begin
			fill_color_q <= cfg_wr_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			vcnt_q     <= '0;
			closed_q   <= 1'b0;
			row_q      <= '0;
			low_q      <= '0;
			high_q     <= '0;
			vmin_q     <= '0;
			vmax_q     <= '0;
			ecnt_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			keep_q     <= '0;
			phase_q    <= 1'b0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			top_q      <= '0;
			neg_q      <= 1'b0;
			done_row_q <= 1'b0;
			tmp_q      <= '0;
			sa_q       <= '0;
			pend_q     <= 1'b0;
			pend_s_q   <= '0;
			pend_e_q   <= '0;
			k_q        <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						case (req_data.action)
							ACT_CLEAR: begin
								vcnt_q   <= '0;
								closed_q <= 1'b0;
								row_q    <= '0;
								low_q    <= '0;
								high_q   <= '0;
								ecnt_q   <= '0;
							end
							ACT_ADD: begin
								if (!closed_q) begin
									if (!vfull) begin
										vcnt_q <= vcnt_q + 1'b1;
										vmin_q <= nmin;
										vmax_q <= nmax;
									end
									// Close with the stored vertices, the new one included unless the store is full
									if (req_data.last_vertex) begin
										closed_q <= 1'b1;
										low_q    <= vfull ? vmin_q : nmin;
										high_q   <= vfull ? vmax_q : nmax;
										row_q    <= {1'b0, vfull ? vmin_q : nmin};
										ecnt_q   <= '0;
									end
								end
							end
							ACT_EMIT: begin
								if (closed_q && row_q <= {1'b0, high_q}) begin
									done_row_q <= row_q == {1'b0, high_q};
									i_q        <= '0;
									st_q       <= S_VRD;
								end
							end
							default: ;
						endcase
					end
				end
				S_VRD: st_q <= S_VCHK;
				S_VCHK: begin
					if ({1'b0, vrd_q.y} == row_q) begin
						cur_x_q <= vrd_q.x;
						cur_y_q <= vrd_q.y;
						phase_q <= 1'b0;
						st_q    <= S_NRD;
					end else if (i_q + 1'b1 == vcnt_q) begin
						i_q  <= CNT_BITS'(1);
						st_q <= (ecnt_q > CNT_BITS'(1)) ? S_SA : S_OA;
						if (ecnt_q <= CNT_BITS'(1)) begin
							i_q    <= '0;
							k_q    <= '0;
							pend_q <= 1'b0;
						end
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_VRD;
					end
				end
				S_NRD: st_q <= S_NCHK;
				S_NCHK: begin
					if (edge_ok) begin
						neg_q <= dx[COORD_BITS];
						top_q <= vrd_q.y;
						st_q  <= S_DIV;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						st_q    <= S_NRD;
					end else if (i_q + 1'b1 == vcnt_q) begin
						i_q    <= (ecnt_q > CNT_BITS'(1)) ? CNT_BITS'(1) : '0;
						k_q    <= '0;
						pend_q <= 1'b0;
						st_q   <= (ecnt_q > CNT_BITS'(1)) ? S_SA : S_OA;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_VRD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ecnt_q <= ecnt_q + 1'b1;
						if (!phase_q) begin
							phase_q <= 1'b1;
							st_q    <= S_NRD;
						end else if (i_q + 1'b1 == vcnt_q) begin
							// Table grows by one here
							i_q    <= (ecnt_q >= CNT_BITS'(1)) ? CNT_BITS'(1) : '0;
							k_q    <= '0;
							pend_q <= 1'b0;
							st_q   <= (ecnt_q >= CNT_BITS'(1)) ? S_SA : S_OA;
						end else begin
							i_q  <= i_q + 1'b1;
							st_q <= S_VRD;
						end
					end
				end
				S_SA: st_q <= S_SB;
				S_SB: begin
					tmp_q <= erd_q;
					j_q   <= i_q;
					st_q  <= S_SC;
				end
				S_SC: begin
					if (tmp_first && j_q == CNT_BITS'(1)) begin
						st_q <= S_SD;
					end else if (tmp_first) begin
						j_q <= j_q - 1'b1;
					end else if (i_q + 1'b1 >= ecnt_q) begin
						i_q    <= '0;
						k_q    <= '0;
						pend_q <= 1'b0;
						st_q   <= S_OA;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_SA;
					end
				end
				S_SD: begin
					if (i_q + 1'b1 >= ecnt_q) begin
						i_q    <= '0;
						k_q    <= '0;
						pend_q <= 1'b0;
						st_q   <= S_OA;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_SA;
					end
				end
				S_OA: begin
					if (i_q + 1'b1 < ecnt_q && k_q < RES_BITS'(RES_LIMIT)) begin
						st_q <= S_OB;
					end else begin
						st_q <= S_OFIN;
					end
				end
				S_OB: begin
					sa_q <= round_clamp(erd_q.x);
					st_q <= S_OC;
				end
				S_OC: begin
					if (!span_ok) begin
						i_q  <= i_q + 2'd2;
						st_q <= S_OA;
					end else if (!pend_q || can_push) begin
						pend_q   <= 1'b1;
						pend_s_q <= sa_q;
						pend_e_q <= eb;
						k_q      <= k_q + 1'b1;
						i_q      <= i_q + 2'd2;
						st_q     <= S_OA;
					end
				end
				S_OFIN: begin
					if (can_push) begin
						i_q    <= '0;
						keep_q <= '0;
						st_q   <= S_KA;
					end
				end
				S_KA: begin
					if (i_q < ecnt_q) begin
						st_q <= S_KB;
					end else begin
						ecnt_q <= keep_q;
						row_q  <= row_next;
						st_q   <= S_IDLE;
					end
				end
				S_KB: begin
					if (keep_ok) begin
						keep_q <= keep_q + 1'b1;
					end
					i_q  <= i_q + 1'b1;
					st_q <= S_KA;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_ecnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= CNT_BITS'(MAX_VERTICES))
		else $error("edge count beyond table depth");

	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CNT_BITS'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	a_rows_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |-> low_q <= high_q)
		else $error("closed polygon with lowest row above highest row");

	a_span_limit: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= RES_BITS'(RES_LIMIT))
		else $error("more spans than the per-row limit");

	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> can_push)
		else $error("response pushed over an unaccepted transaction");
`endif

endmodule

### test/tb_scanline_polygon_fill_unit.sv
// ----------------------------------------------------------------------------
// tb_scanline_polygon_fill_unit
// Self-checking bench for the scanline polygon fill unit: polygons are loaded
// vertex by vertex and walked row by row, and every response transaction is
// compared with a span predictor kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module tb_scanline_polygon_fill_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spf_pkg::*;

	localparam logic [1:0] ACT_NOP     = 2'd3;
	localparam int         CYCLE_LIMIT = 1500000;
	localparam int         DRAIN_WAIT  = 4000;

	// Span predictor and store of expected responses.
	class span_scoreboard;
		rsp_t        pending[$];
		int          errors;
		int          spans_seen;
		int          rows_seen;
		logic [23:0] colour;
		logic [11:0] vx[MAX_VERTICES];
		logic [11:0] vy[MAX_VERTICES];
		int          nvert;
		bit          closed;
		int          row;
		int          low_row;
		int          high_row;
		longint      ex[MAX_VERTICES];
		longint      es[MAX_VERTICES];
		int          etop[MAX_VERTICES];
		int          nedge;

		function new();
			errors = 0;
			spans_seen = 0;
			rows_seen = 0;
			colour = '0;
			nvert = 0;
			closed = 0;
			row = 0;
			low_row = 0;
			high_row = 0;
			nedge = 0;
		endfunction

		function void push(logic [1:0] st, logic sv, int y, int s, int e, logic [23:0] c,
				logic last, logic done);
			rsp_t r;
			r.status = st;
			r.span_valid = sv;
			r.span_y = y[11:0];
			r.span_start = s[11:0];
			r.span_end = e[11:0];
			r.span_color = c;
			r.last_of_run = last;
			r.polygon_done = done;
			pending.push_back(r);
		endfunction

		function void start_edge(int lo, int hi);
			longint dx, dy, mag, q;
			if (vy[hi] <= vy[lo] || nedge >= MAX_VERTICES) begin
				return;
			end
			dx = longint'(vx[hi]) - longint'(vx[lo]);
			dy = longint'(vy[hi]) - longint'(vy[lo]);
			mag = dx < 0 ? -dx : dx;
			q = (mag * (64'sd1 <<< FRAC_BITS) + dy / 2) / dy;
			ex[nedge] = longint'(vx[lo]) <<< FRAC_BITS;
			es[nedge] = dx < 0 ? -q : q;
			etop[nedge] = vy[hi];
			nedge++;
		endfunction

		function int to_pixel(longint x);
			longint r;
			r = (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (r < 0) begin
				return 0;
			end
			if (r > (1 << COORD_BITS) - 1) begin
				return (1 << COORD_BITS) - 1;
			end
			return int'(r);
		endfunction

		function void predict_row();
			int     k, keep, s, e, j;
			logic   done;
			longint tx, ts;
			int     tt;
			done = (row == high_row);
			for (int i = 0; i < nvert; i++) begin
				if (vy[i] == row) begin
					start_edge(i, i == 0 ? nvert - 1 : i - 1);
					start_edge(i, i == nvert - 1 ? 0 : i + 1);
				end
			end
			// Insertion sort by x, then by slope.
			for (int i = 1; i < nedge; i++) begin
				j = i;
				while (j > 0 && (ex[j] < ex[j-1] || (ex[j] == ex[j-1] && es[j] < es[j-1]))) begin
					tx = ex[j]; ts = es[j]; tt = etop[j];
					ex[j] = ex[j-1]; es[j] = es[j-1]; etop[j] = etop[j-1];
					ex[j-1] = tx; es[j-1] = ts; etop[j-1] = tt;
					j--;
				end
			end
			k = 0;
			for (int i = 0; i + 1 < nedge && k < RES_LIMIT; i += 2) begin
				s = to_pixel(ex[i]);
				e = to_pixel(ex[i+1]);
				if (s < e) begin
					push(STAT_OK, 1'b1, row, s, e, colour, 1'b0, done);
					k++;
				end
			end
			if (k == 0) begin
				push(STAT_OK, 1'b0, row, 0, 0, '0, 1'b0, done);
			end
			spans_seen += k;
			rows_seen++;
			pending[pending.size()-1].last_of_run = 1'b1;
			// Step x and drop edges that end on the next row.
			keep = 0;
			for (int i = 0; i < nedge; i++) begin
				if (row + 1 < etop[i]) begin
					ex[keep] = ex[i] + es[i];
					es[keep] = es[i];
					etop[keep] = etop[i];
					keep++;
				end
			end
			nedge = keep;
			row = row + 1;
		endfunction

		function void note_request(req_t q);
			logic [1:0] st;
			case (q.action)
				ACT_CLEAR: begin
					nvert = 0; closed = 0; row = 0; low_row = 0; high_row = 0; nedge = 0;
					push(STAT_OK, 0, 0, 0, 0, '0, 1, 0);
				end
				ACT_ADD: begin
					st = STAT_OK;
					if (closed) begin
						push(STAT_DROP, 0, 0, 0, 0, '0, 1, 0);
						return;
					end
					if (nvert < MAX_VERTICES) begin
						vx[nvert] = q.vertex_x;
						vy[nvert] = q.vertex_y;
						nvert++;
					end else begin
						st = STAT_DROP;
					end
					if (q.last_vertex && nvert > 0) begin
						closed = 1;
						low_row = vy[0];
						high_row = vy[0];
						for (int i = 1; i < nvert; i++) begin
							if (vy[i] < low_row) low_row = vy[i];
							if (vy[i] > high_row) high_row = vy[i];
						end
						row = low_row;
						nedge = 0;
					end
					push(st, 0, 0, 0, 0, '0, 1, 0);
				end
				ACT_EMIT: begin
					if (!closed || row > high_row) begin
						push(STAT_NOROW, 0, 0, 0, 0, '0, 1, 0);
					end else begin
						predict_row();
					end
				end
				default: push(STAT_OK, 0, 0, 0, 0, '0, 1, 0);
			endcase
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t ns: mismatch on %s, expected 0x%0h, actual 0x%0h",
					$realtime, field, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t ns: unexpected response 0x%0h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			report("status", want.status, got.status);
			report("span_valid", want.span_valid, got.span_valid);
			report("span_y", want.span_y, got.span_y);
			report("span_start", want.span_start, got.span_start);
			report("span_end", want.span_end, got.span_end);
			report("span_color", want.span_color, got.span_color);
			report("last_of_run", want.last_of_run, got.last_of_run);
			report("polygon_done", want.polygon_done, got.polygon_done);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req_data;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp_data;
	logic        cfg_wr_en;
	logic [23:0] cfg_wr_data;

	span_scoreboard sb;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             requests_sent;
	int             cycles;

	scanline_polygon_fill_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_data    (rsp_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver back-pressure: re-roll the stall on every falling edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Check every response transaction on the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_response(rsp_data);
		end
	end

	// Watchdog: abandon a run that has hung.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d responses outstanding", $realtime,
				sb.pending.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one request transaction, idling first at the sender's rate, and hold
	// it until the unit takes it.
	task automatic send(logic [1:0] act, int x, int y, bit last);
		req_t q;
		q.action = act;
		q.vertex_x = x[11:0];
		q.vertex_y = y[11:0];
		q.last_vertex = last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req_data <= req_t'($urandom);
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= q;
		do begin
			@(posedge clk);
		end while (req_stall);
		sb.note_request(q);
		requests_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait until every expected response is back and the unit is
	// idle again.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(negedge clk);
		end
		while (req_stall) begin
			@(negedge clk);
		end
		repeat (5) @(negedge clk);
	endtask

	// Write the fill colour; only called with the unit idle.
	task automatic set_colour(logic [23:0] c);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.colour = c;
	endtask

	// Load a random polygon and walk it. Keep the rows few so the run stays
	// short; optionally walk one row past the top.
	task automatic random_polygon(int nv, int height, bit overrun);
		int base, lo, hi, x, y;
		base = $urandom_range(0, 4095 - height);
		lo = 4096;
		hi = -1;
		send(ACT_CLEAR, $urandom, $urandom, 1'($urandom));
		for (int i = 0; i < nv; i++) begin
			case ($urandom_range(0, 5))
				0:       x = 0;
				1:       x = 4095;
				default: x = $urandom_range(0, 4095);
			endcase
			y = base + $urandom_range(0, height);
			if (i < MAX_VERTICES) begin
				if (y < lo) lo = y;
				if (y > hi) hi = y;
			end
			send(ACT_ADD, x, y, i == nv - 1);
		end
		for (int r = lo; r <= hi + (overrun ? 1 : 0); r++) begin
			send(ACT_EMIT, $urandom, $urandom, 1'($urandom));
		end
	endtask

	// Random traffic: mostly well-formed polygons, some noise.
	task automatic random_traffic(int quota);
		int target;
		target = requests_sent + quota;
		while (requests_sent < target) begin
			case ($urandom_range(0, 9))
				0:       send(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom));
				1:       send(ACT_EMIT, $urandom, $urandom, 0);
				default: random_polygon($urandom_range(3, 8), $urandom_range(0, 6),
						1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		requests_sent = 0;
		cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: odd actions before any polygon exists.
		set_colour(24'hFFFFFF);
		send(ACT_EMIT, 0, 0, 0);
		send(ACT_NOP, 4095, 4095, 1);
		send(ACT_CLEAR, 0, 0, 0);
		// Triangle spanning the full x range, with a horizontal base.
		send(ACT_ADD, 0, 0, 0);
		send(ACT_ADD, 4095, 0, 0);
		send(ACT_ADD, 2048, 3, 1);
		send(ACT_ADD, 7, 7, 1);
		repeat (4) send(ACT_EMIT, 0, 0, 0);
		send(ACT_EMIT, 0, 0, 0);
		// Sliver whose first and last rows give no span, then a bow-tie.
		send(ACT_CLEAR, 0, 0, 0);
		send(ACT_ADD, 100, 4093, 0);
		send(ACT_ADD, 100, 4095, 0);
		send(ACT_ADD, 101, 4094, 1);
		repeat (3) send(ACT_EMIT, 0, 0, 0);
		send(ACT_CLEAR, 0, 0, 0);
		send(ACT_ADD, 10, 20, 0);
		send(ACT_ADD, 30, 24, 0);
		send(ACT_ADD, 30, 20, 0);
		send(ACT_ADD, 10, 24, 1);
		repeat (5) send(ACT_EMIT, 0, 0, 0);

		// Full vertex store, closed by a dropped vertex.
		set_colour(24'h000000);
		random_polygon(MAX_VERTICES + 2, 3, 1);

		// Phase one: sender idles 30 %, receiver 53 %.
		set_colour(24'($urandom_range(0, 24'hFFFFFF)));
		send_idle_pct = 30;
		recv_idle_pct = 53;
		random_traffic(50);

		// Phase two: roles swapped.
		set_colour(24'h800001);
		send_idle_pct = 53;
		recv_idle_pct = 30;
		random_traffic(50);

		// Phase three: no idling on either side.
		set_colour(24'($urandom_range(0, 24'hFFFFFF)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(45);

		drain();
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("Covered %0d requests, %0d scanlines and %0d spans over three idling phases.",
			requests_sent, sb.rows_seen, sb.spans_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
design/spf_pkg.sv
design/spf_div.sv
design/scanline_polygon_fill_unit.sv
test/tb_scanline_polygon_fill_unit.sv
